// ===== rtl/core/prle_pkg.sv =====
// Shared constants and control types of the palette run-length encoder.
// Used by prle_palette and by the top level palette_run_length_encoder.
`default_nettype none

package prle_pkg;

  // Default values of the top-level parameters.
  localparam int TILE_BITS_DEF     = 32;
  localparam int PALETTE_DEPTH_DEF = 16;
  localparam int RUN_BITS_DEF      = 16;

  // Fixed field widths of the stream ports.
  localparam int TILE_WORD_W  = 32;
  localparam int RUN_LENGTH_W = 16;
  localparam int PAL_INDEX_W  = 4;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 56;
  localparam int OUT_TUSER_W  = 2;

  // Bit positions inside the result tuser.
  localparam int USER_FIRST_USE = 0;
  localparam int USER_OVERFLOW  = 1;

  // Commands from the run sequencer to the palette unit.
  typedef struct packed {
    logic start;  // begin a search for the held tile
    logic clear;  // forget all palette entries
  } pal_cmd_t;

  // Status from the palette unit back to the run sequencer.
  typedef struct packed {
    logic done;   // search finished this cycle
    logic hit;    // tile was found in the palette
    logic full;   // every palette entry is in use
  } pal_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/prle_palette.sv =====
// Palette store with its serial search unit: one entry is read and compared per cycle.
// Depends on prle_pkg for the command and status types.
`default_nettype none

module prle_palette
  import prle_pkg::*;
#(
  parameter int TILE_BITS     = TILE_BITS_DEF,
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire pal_cmd_t                         cmd,
  input  wire logic [TILE_BITS-1:0]             key,
  output pal_stat_t                             stat,
  output logic [$clog2(PALETTE_DEPTH)-1:0]      index,
  output logic [TILE_BITS-1:0]                  word
);

  localparam int IW = $clog2(PALETTE_DEPTH);
  localparam int UW = $clog2(PALETTE_DEPTH + 1);
  localparam logic [UW-1:0] DEPTH_U = UW'(PALETTE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(PALETTE_DEPTH - 1);

  logic [TILE_BITS-1:0] mem [PALETTE_DEPTH];
  logic [TILE_BITS-1:0] rd_data;

  logic [UW-1:0] used;
  logic [UW-1:0] scan;
  logic          active;
  logic          pend_valid;
  logic [IW-1:0] pend_idx;

  logic hit;
  logic exhausted;
  logic done;
  logic full;
  logic issue;
  logic append;

  assign full      = (used == DEPTH_U);
  assign hit       = active && pend_valid && (rd_data == key);
  assign exhausted = active && !pend_valid && (scan == used);
  assign done      = hit || exhausted;
  assign issue     = active && !hit && (scan < used);
  assign append    = exhausted && !full;

  assign stat.done = done;
  assign stat.hit  = hit;
  assign stat.full = full;

  // On a miss with a full palette the last read was the top entry, so the
  // read register still holds the word that the reused entry carries.
  always_comb begin
    if (hit) begin
      index = pend_idx;
      word  = rd_data;
    end else if (full) begin
      index = LAST_IDX;
      word  = rd_data;
    end else begin
      index = used[IW-1:0];
      word  = key;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[scan[IW-1:0]];
    end
    if (append) begin
      mem[used[IW-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      scan       <= '0;
      active     <= 1'b0;
      pend_valid <= 1'b0;
      pend_idx   <= '0;
    end else begin
      if (cmd.clear) begin
        used <= '0;
      end else if (append) begin
        used <= used + UW'(1);
      end

      if (cmd.start) begin
        active     <= 1'b1;
        scan       <= '0;
        pend_valid <= 1'b0;
      end else begin
        if (done) begin
          active <= 1'b0;
        end
        pend_valid <= issue;
        if (issue) begin
          pend_idx <= scan[IW-1:0];
          scan     <= scan + UW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/palette_run_length_encoder.sv =====
// Top level of the palette run-length encoder: run sequencer and result register.
// Depends on prle_pkg and instantiates the palette search unit prle_palette.
//
//   Port group  Dir  tdata                      tuser                     tlast
//   s_axis      in   tile_word                  -                         map_end
//   m_axis      out  run_length, palette_index, first_use,                last_run
//                    run_tile                   palette_overflow
//
// A tile that extends the current run is accepted and then compared.
// A tile that changes the run closes the current run, then searches the
// palette entries in use one entry per cycle through a single registered
// read port and one comparator.
// Each result occupies the output register until it is taken; a stall there
// holds the sequencer in its emit state. Reset is synchronous and needs no
// clearing pass; the palette entry count simply returns to zero.
`default_nettype none

module palette_run_length_encoder
  import prle_pkg::*;
#(
  parameter int TILE_BITS     = TILE_BITS_DEF,
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int RUN_BITS      = RUN_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] tile_word
  input  wire logic                   s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // run_length, palette_index,
                                                      // run_tile, zero pad
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser,   // first_use, palette_overflow
  output logic                        m_axis_tlast
);

  localparam int IW = $clog2(PALETTE_DEPTH);
  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_SPLIT  = 6'b000100,
    S_CLOSE  = 6'b001000,
    S_SEARCH = 6'b010000,
    S_LAST   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [TILE_BITS-1:0] tile_q;
  logic                 end_q;
  logic [TILE_BITS-1:0] run_word, run_word_next;
  logic [IW-1:0]        run_index, run_index_next;
  logic [RUN_BITS-1:0]  run_count, run_count_next;
  logic                 run_new, run_new_next;
  logic                 overflow, overflow_next;
  logic                 started, started_next;

  logic                   o_valid;
  logic [OUT_TDATA_W-1:0] o_data;
  logic [OUT_TUSER_W-1:0] o_user;
  logic                   o_last;

  pal_cmd_t             cmd;
  pal_stat_t            stat;
  logic [IW-1:0]        pal_index;
  logic [TILE_BITS-1:0] pal_word;

  logic   accept;
  logic   slot_free;
  logic   emit_en;
  logic   emit_last;
  logic   tile_eq;
  state_t after_item;

  prle_palette #(
    .TILE_BITS     (TILE_BITS),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .key   (tile_q),
    .stat  (stat),
    .index (pal_index),
    .word  (pal_word)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !o_valid || m_axis_tready;
  assign tile_eq       = (tile_q == run_word);
  assign after_item    = end_q ? S_LAST : S_IDLE;

  always_comb begin
    state_next     = state;
    run_word_next  = run_word;
    run_index_next = run_index;
    run_count_next = run_count;
    run_new_next   = run_new;
    overflow_next  = overflow;
    started_next   = started;
    emit_en        = 1'b0;
    emit_last      = 1'b0;
    cmd            = '0;

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (started) begin
            state_next = S_CHECK;
          end else begin
            // The first tile of a map opens a run without a compare.
            cmd.start  = 1'b1;
            state_next = S_SEARCH;
          end
        end
      end
      S_CHECK: begin
        if (!tile_eq) begin
          state_next = S_CLOSE;
        end else if (run_count == RUN_MAX) begin
          state_next = S_SPLIT;
        end else begin
          run_count_next = run_count + RUN_BITS'(1);
          state_next     = after_item;
        end
      end
      S_SPLIT: begin
        if (slot_free) begin
          emit_en        = 1'b1;
          run_count_next = RUN_BITS'(1);
          run_new_next   = 1'b0;
          state_next     = after_item;
        end
      end
      S_CLOSE: begin
        if (slot_free) begin
          emit_en    = 1'b1;
          cmd.start  = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.done) begin
          run_index_next = pal_index;
          run_word_next  = pal_word;
          run_new_next   = !stat.hit && !stat.full;
          overflow_next  = overflow || (!stat.hit && stat.full);
          run_count_next = RUN_BITS'(1);
          started_next   = 1'b1;
          state_next     = after_item;
        end
      end
      S_LAST: begin
        if (slot_free) begin
          emit_en        = 1'b1;
          emit_last      = 1'b1;
          cmd.clear      = 1'b1;
          run_index_next = '0;
          run_count_next = '0;
          run_new_next   = 1'b0;
          overflow_next  = 1'b0;
          started_next   = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      run_index <= '0;
      run_count <= '0;
      run_new   <= 1'b0;
      overflow  <= 1'b0;
      started   <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      run_index <= run_index_next;
      run_count <= run_count_next;
      run_new   <= run_new_next;
      overflow  <= overflow_next;
      started   <= started_next;
      if (emit_en) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    run_word <= run_word_next;
    if (accept) begin
      tile_q <= TILE_BITS'(s_axis_tdata[TILE_WORD_W-1:0]);
      end_q  <= s_axis_tlast;
    end
    if (emit_en) begin
      o_data <= OUT_TDATA_W'({TILE_WORD_W'(run_word), PAL_INDEX_W'(run_index),
                              RUN_LENGTH_W'(run_count)});
      o_user[USER_FIRST_USE] <= run_new;
      o_user[USER_OVERFLOW]  <= overflow;
      o_last                 <= emit_last;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_data;
  assign m_axis_tuser  = o_user;
  assign m_axis_tlast  = o_last;

endmodule

`default_nettype wire

// ===== tb/prle_run_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the palette run-length encoder: it watches both stream channels,
// predicts the run transactions from the accepted tiles and compares them. Uses prle_pkg.
module prle_run_checker
  import prle_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  input  wire logic                   s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tlast,
  input  wire logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input  wire logic                   m_axis_tlast,
  output int                          mismatches,
  output int                          outstanding
);

  localparam int DEPTH    = PALETTE_DEPTH_DEF;
  localparam int IDX_LSB  = RUN_LENGTH_W;
  localparam int TILE_LSB = RUN_LENGTH_W + PAL_INDEX_W;

  typedef struct {
    logic [RUN_LENGTH_W-1:0] run_length;
    logic [PAL_INDEX_W-1:0]  palette_index;
    logic [TILE_WORD_W-1:0]  run_tile;
    logic                    first_use;
    logic                    last_run;
    logic                    palette_overflow;
  } run_rec_t;

  // Own copy of the encoder state.
  logic [TILE_WORD_W-1:0]  pal_words [DEPTH];
  logic [PAL_INDEX_W:0]    pal_used;
  logic [PAL_INDEX_W-1:0]  cur_index;
  logic [RUN_LENGTH_W-1:0] cur_len;
  logic                    cur_first;
  logic                    overflow_flag;
  logic                    in_map;

  run_rec_t pending_runs[$];
  run_rec_t oldest_run;
  int       fail_total = 0;

  task automatic queue_run(input logic fin);
    run_rec_t r;
    r.run_length       = cur_len;
    r.palette_index    = cur_index;
    r.run_tile         = pal_words[cur_index];
    r.first_use        = cur_first;
    r.last_run         = fin;
    r.palette_overflow = overflow_flag;
    pending_runs.insert(pending_runs.size(), r);
  endtask

  // Looks the tile up in the palette, appends it if unseen and room is left, and opens a run of one.
  task automatic start_run(input logic [TILE_WORD_W-1:0] word);
    int slot;
    slot = -1;
    for (int i = 0; i < pal_used; i++) begin
      if (slot < 0 && pal_words[i] == word) slot = i;
    end
    if (slot >= 0) begin
      cur_index = PAL_INDEX_W'(slot);
      cur_first = 1'b0;
    end else if (pal_used < DEPTH) begin
      pal_words[pal_used[PAL_INDEX_W-1:0]] = word;
      cur_index = pal_used[PAL_INDEX_W-1:0];
      pal_used++;
      cur_first = 1'b1;
    end else begin
      // A full palette folds every unseen tile onto the last entry.
      overflow_flag = 1'b1;
      cur_index     = PAL_INDEX_W'(DEPTH - 1);
      cur_first     = 1'b0;
    end
    cur_len = RUN_LENGTH_W'(1);
  endtask

  task automatic encode_tile(input logic [TILE_WORD_W-1:0] word, input logic fin);
    if (!in_map) begin
      start_run(word);
      in_map = 1'b1;
    end else if (pal_words[cur_index] == word) begin
      if (cur_len == '1) begin
        queue_run(1'b0);
        cur_len   = RUN_LENGTH_W'(1);
        cur_first = 1'b0;
      end else begin
        cur_len++;
      end
    end else begin
      queue_run(1'b0);
      start_run(word);
    end
    if (fin) begin
      queue_run(1'b1);
      pal_used      = '0;
      cur_index     = '0;
      cur_len       = '0;
      cur_first     = 1'b0;
      overflow_flag = 1'b0;
      in_map        = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pal_used      = '0;
      cur_index     = '0;
      cur_len       = '0;
      cur_first     = 1'b0;
      overflow_flag = 1'b0;
      in_map        = 1'b0;
      pending_runs.delete();
    end else begin
      // Results are checked before this edge's tile is predicted; a tile cannot
      // produce a result at the edge that accepts it.
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_runs.size() == 0) begin
          $error("unexpected run transaction: tdata 0x%0h", m_axis_tdata);
          fail_total++;
        end else begin
          oldest_run = pending_runs.pop_front();
          check_field("run_length", 32'(oldest_run.run_length),
                      32'(m_axis_tdata[0 +: RUN_LENGTH_W]));
          check_field("palette_index", 32'(oldest_run.palette_index),
                      32'(m_axis_tdata[IDX_LSB +: PAL_INDEX_W]));
          check_field("run_tile", oldest_run.run_tile, m_axis_tdata[TILE_LSB +: TILE_WORD_W]);
          check_field("first_use", 32'(oldest_run.first_use),
                      32'(m_axis_tuser[USER_FIRST_USE]));
          check_field("last_run", 32'(oldest_run.last_run), 32'(m_axis_tlast));
          check_field("palette_overflow", 32'(oldest_run.palette_overflow),
                      32'(m_axis_tuser[USER_OVERFLOW]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        encode_tile(s_axis_tdata[TILE_WORD_W-1:0], s_axis_tlast);
      end
    end
    mismatches  <= fail_total;
    outstanding <= pending_runs.size();
  end

endmodule

// ===== tb/palette_run_length_encoder_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the palette run-length encoder: clock, reset, tile stimulus and
// receiver stalls. Depends on prle_pkg, palette_run_length_encoder and prle_run_checker.
module palette_run_length_encoder_tb;
  import prle_pkg::*;

  typedef enum int {RX_OPEN, RX_COIN, RX_STRIDE, RX_SPARSE} rx_mode_e;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  int   mismatches;
  int   outstanding;
  logic hold_req = 1'b0;
  bit   paced = 1'b1;
  int   burst_left = 0;

  always #5 clk = ~clk;

  palette_run_length_encoder DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  prle_run_checker run_checker (.*);

  // Offers one tile and returns at the edge that accepts it. Paced traffic comes
  // in bursts with idle gaps between them.
  task automatic send_tile(input logic [TILE_WORD_W-1:0] word, input logic fin);
    int gap;
    gap = 0;
    if (paced) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end
      burst_left--;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  initial begin
    int                     sent;
    int                     map_len;
    int                     pool_size;
    int                     keep_pct;
    int                     i;
    logic [TILE_WORD_W-1:0] pool [24];
    logic [TILE_WORD_W-1:0] word;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Single-tile maps at both extremes of the tile word.
    send_tile(32'h0000_0000, 1'b1);
    send_tile(32'hFFFF_FFFF, 1'b1);
    // Run, change, return to a known entry, and a change on the final tile.
    send_tile(32'hFFFF_FFFF, 1'b0);
    send_tile(32'hFFFF_FFFF, 1'b0);
    send_tile(32'h0000_0000, 1'b0);
    send_tile(32'hFFFF_FFFF, 1'b0);
    send_tile(32'h0000_0000, 1'b1);
    // Seventeen distinct tiles overflow the palette; the last entry is then reused.
    for (i = 0; i < 17; i++) send_tile(32'h1 << i, 1'b0);
    send_tile(32'h1 << 15, 1'b0);
    send_tile(32'h1 << 16, 1'b0);
    send_tile(32'h1, 1'b1);

    // One run of identical tiles sent back to back.
    paced = 1'b0;
    for (i = 0; i < 40; i++) send_tile(32'hA5A5_5A5A, 1'b0);
    send_tile(32'h0000_0000, 1'b1);
    paced = 1'b1;

    sent = 0;
    while (sent < 680) begin
      case ($urandom_range(0, 9))
        0: begin
          map_len   = 1;
          pool_size = 2;
        end
        1, 2: begin
          map_len   = $urandom_range(20, 60);
          pool_size = $urandom_range(14, 24);
        end
        3: begin
          map_len   = $urandom_range(100, 300);
          pool_size = $urandom_range(1, 4);
        end
        default: begin
          map_len   = $urandom_range(2, 30);
          pool_size = $urandom_range(1, 8);
        end
      endcase
      if (map_len > 680 - sent) map_len = 680 - sent;
      for (i = 0; i < pool_size; i++) begin
        if ($urandom_range(0, 7) == 0) pool[i] = $urandom_range(0, 1) ? '1 : '0;
        else pool[i] = $urandom();
      end
      keep_pct = $urandom_range(0, 95);
      word = pool[$urandom_range(0, pool_size - 1)];
      for (i = 0; i < map_len; i++) begin
        if (i > 0 && $urandom_range(0, 99) >= keep_pct) begin
          if ($urandom_range(0, 9) == 0) word = $urandom();
          else word = pool[$urandom_range(0, pool_size - 1)];
        end
        send_tile(word, i == map_len - 1);
      end
      sent += map_len;
      if (sent > 150) hold_req <= 1'b1;
    end
    s_axis_tvalid <= 1'b0;

    // Let the checker register the runs of the final tile before waiting on them.
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: stretches of differing stall patterns, plus one long hold-off that
  // backs the encoder up while tiles keep being offered.
  initial begin
    rx_mode_e mode;
    int       span;
    int       stride;
    int       tick;
    bit       hold_served;
    hold_served = 1'b0;
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      mode   = rx_mode_e'($urandom_range(0, 3));
      span   = $urandom_range(10, 200);
      stride = $urandom_range(2, 6);
      for (tick = 0; tick < span; tick++) begin
        case (mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_STRIDE: m_axis_tready <= (tick % stride == 0);
          default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    #12_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/prle_pkg.sv
rtl/core/prle_palette.sv
rtl/core/palette_run_length_encoder.sv
tb/prle_run_checker.sv
tb/palette_run_length_encoder_tb.sv
